// File: sv/mpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared constants and types for the MGCP payload classifier: counter width,
// verb table, marker word and the control struct of the window cells.
// ----------------------------------------------------------------------------
package mpc_pkg;

	localparam int INDEX_WIDTH = 16;
	localparam int WIN_CELLS   = 4;
	localparam int VERB_COUNT  = 9;

	localparam logic [INDEX_WIDTH-1:0] IDX_MAX          = {INDEX_WIDTH{1'b1}};
	localparam logic [INDEX_WIDTH-1:0] VERB_INDEX       = INDEX_WIDTH'(4);
	localparam logic [INDEX_WIDTH-1:0] MIN_LAST_INDEX   = INDEX_WIDTH'(7);
	localparam logic [INDEX_WIDTH-1:0] MARKER_MIN_INDEX = INDEX_WIDTH'(8);

	localparam logic [7:0] LINE_FEED = 8'h0a;

	typedef logic [39:0] word5_t;

	localparam word5_t MARKER_WORD = {"M", "G", "C", "P", " "};

	localparam word5_t VERB_TABLE [VERB_COUNT] = '{
		{"A", "U", "E", "P", " "},
		{"A", "U", "C", "X", " "},
		{"C", "R", "C", "X", " "},
		{"D", "L", "C", "X", " "},
		{"E", "P", "C", "F", " "},
		{"M", "D", "C", "X", " "},
		{"N", "T", "F", "Y", " "},
		{"R", "Q", "N", "T", " "},
		{"R", "S", "I", "P", " "}
	};

	// Control shared by every window cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// Match the five-byte window against the verb list
	function automatic logic is_verb(input word5_t w);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < VERB_COUNT; k++) begin
			if (VERB_TABLE[k] == w) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage
`default_nettype wire

// File: sv/mpc_window_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_window_cell
// One byte of the sliding window. Takes its neighbor's byte on every accepted
// transaction and clears at the end of a payload.
// ----------------------------------------------------------------------------
module mpc_window_cell (
	input  wire                    clk,
	input  wire                    arst_n,
	input  mpc_pkg::cell_ctrl_t    ctrl,
	input  wire  [7:0]             din,
	output logic [7:0]             dout
);

	logic [7:0] byte_q;

	// Shift in the neighbor byte, drop everything on end of payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (ctrl.shift) begin
			if (ctrl.clear) begin
				byte_q <= 8'h00;
			end else begin
				byte_q <= din;
			end
		end
	end

	assign dout = byte_q;

endmodule
`default_nettype wire

// File: sv/mpc_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_match
// Byte counter, verb and marker flags, and the verdict for the final byte.
// ----------------------------------------------------------------------------
module mpc_match (
	input  wire                  clk,
	input  wire                  arst_n,
	input  mpc_pkg::cell_ctrl_t  ctrl,
	input  mpc_pkg::word5_t      window,
	input  wire  [7:0]           payload_byte,
	output logic                 verdict
);

	logic [mpc_pkg::INDEX_WIDTH-1:0] byte_index_q;
	logic                            verb_ok_q;
	logic                            marker_found_q;
	logic                            verb_hit;
	logic                            verb_ok_now;
	logic                            marker_hit;

	// Compare the window holding the incoming byte
	assign verb_hit    = (byte_index_q == mpc_pkg::VERB_INDEX) && mpc_pkg::is_verb(window);
	assign verb_ok_now = verb_ok_q || verb_hit;
	assign marker_hit  = (byte_index_q >= mpc_pkg::MARKER_MIN_INDEX) &&
	                     (window == mpc_pkg::MARKER_WORD);

	assign verdict = (byte_index_q >= mpc_pkg::MIN_LAST_INDEX) &&
	                 (payload_byte == mpc_pkg::LINE_FEED) &&
	                 verb_ok_now && marker_found_q;

	// Advance counter and flags; clear on the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= '0;
			verb_ok_q      <= 1'b0;
			marker_found_q <= 1'b0;
		end else if (ctrl.shift) begin
			if (ctrl.clear) begin
				byte_index_q   <= '0;
				verb_ok_q      <= 1'b0;
				marker_found_q <= 1'b0;
			end else begin
				verb_ok_q <= verb_ok_now;
				if (marker_hit) begin
					marker_found_q <= 1'b1;
				end
				if (byte_index_q != mpc_pkg::IDX_MAX) begin
					byte_index_q <= byte_index_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/mgcp_payload_classifier_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgcp_payload_classifier_top
// Classifies a UDP payload, streamed one byte per transaction, as MGCP or not.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries payload_byte and is_last, one
//   byte per transaction, first byte first; is_last marks the final byte.
//   Output channel (out_valid / out_ready) carries is_mgcp, one transaction
//   per payload, produced only for the final byte.
//   Throughput: one byte per cycle while the output is not stalled, payloads back to back with no gap. The
//   window is a row of four byte cells that shift on every accepted byte;
//   verb and marker compares see the cells plus the incoming byte.
//   Latency: is_mgcp is valid the cycle after the final byte is accepted.
//   Stall: the verdict sits in an output register; while it waits and
//   out_ready is low, in_ready drops and no byte of any kind is accepted.
//   Bytes flow again in the cycle that out_ready drains the verdict, so a
//   stall on the output costs the input exactly the stalled cycles.
//   Reset: arst_n clears the window, counter, flags and output valid; the
//   block is ready for a new payload on the first cycle after reset.
// ----------------------------------------------------------------------------
module mgcp_payload_classifier_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] payload_byte,
	input  wire        is_last,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       is_mgcp
);

	mpc_pkg::cell_ctrl_t ctrl;
	mpc_pkg::word5_t     window;
	logic [7:0]          cell_din  [mpc_pkg::WIN_CELLS];
	logic [7:0]          cell_dout [mpc_pkg::WIN_CELLS];
	logic                verdict;
	logic                in_accept;
	logic                out_valid_q;
	logic                is_mgcp_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	assign ctrl = '{shift: in_accept, clear: is_last};

	// Chain of window cells, newest byte enters cell 0
	for (genvar i = 0; i < mpc_pkg::WIN_CELLS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_din[i] = payload_byte;
		end else begin : g_link
			assign cell_din[i] = cell_dout[i-1];
		end
		mpc_window_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.din    (cell_din[i]),
			.dout   (cell_dout[i])
		);
	end

	assign window = {cell_dout[3], cell_dout[2], cell_dout[1], cell_dout[0], payload_byte};

	mpc_match u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.window       (window),
		.payload_byte (payload_byte),
		.verdict      (verdict)
	);

	// Hold the verdict until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept && is_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_mgcp_q <= 1'b0;
		end else if (in_accept && is_last) begin
			is_mgcp_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign is_mgcp   = is_mgcp_q;

endmodule
`default_nettype wire

// File: sv/mpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_checker
// Port-level checks of the MGCP payload classifier, bound to the top level.
// ----------------------------------------------------------------------------
module mpc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       is_last,
	input wire       out_valid,
	input wire       out_ready,
	input wire       is_mgcp
);

	// Hold a stalled verdict
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the transaction completed");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(is_mgcp))
		else $error("is_mgcp changed while stalled");

	// A final byte yields exactly one verdict next cycle
	a_last_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_last |=> out_valid)
		else $error("no verdict after the final byte");

	a_mid_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !is_last |=> !out_valid)
		else $error("verdict produced for a non-final byte");

	// Never block input while the output register is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with no pending verdict");

endmodule

bind mgcp_payload_classifier_top mpc_checker u_mpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.is_last      (is_last),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.is_mgcp      (is_mgcp)
);
`default_nettype wire

// File: verif/mgcp_payload_classifier_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgcp_payload_classifier_top_test
// Streams UDP payloads byte by byte into the MGCP classifier and checks every
// verdict against a cycle-free predictor of the verb, marker, length and
// line-feed rules, under sender and receiver idling and a long output stall.
// ----------------------------------------------------------------------------
module mgcp_payload_classifier_top_test;

	typedef enum int {SHAPE_GOOD, SHAPE_BROKEN, SHAPE_NOISE} shape_t;
	typedef enum int {
		FLAW_BIT_FLIP, FLAW_BAD_END, FLAW_TRUNCATE,
		FLAW_NO_VERB, FLAW_BAD_MARKER, FLAW_TRAILER
	} flaw_t;

	localparam int PHASE_BYTES      = 430;
	localparam int LONG_FILL        = 300;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT      = 20000;

	// Predict verdicts per payload and compare them in arrival order
	class mgcp_verdict_scoreboard;
		logic [mpc_pkg::INDEX_WIDTH-1:0] byte_count;
		mpc_pkg::word5_t window;
		bit verb_seen;
		bit marker_seen;
		bit expected_verdicts[$];
		int errors;
		int bytes_seen;
		int payloads;
		int mgcp_hits;

		function new();
			start_payload();
		endfunction

		function void start_payload();
			byte_count  = '0;
			window      = '0;
			verb_seen   = 1'b0;
			marker_seen = 1'b0;
		endfunction

		function void note_byte(logic [7:0] value, logic last);
			logic [mpc_pkg::INDEX_WIDTH-1:0] pos;
			pos = byte_count;
			bytes_seen++;
			window = {window[31:0], value};
			// the verb is judged once, when the fifth byte lands
			if (pos == mpc_pkg::VERB_INDEX) begin
				for (int k = 0; k < mpc_pkg::VERB_COUNT; k++) begin
					if (mpc_pkg::VERB_TABLE[k] == window)
						verb_seen = 1'b1;
				end
			end
			if (last) begin
				expected_verdicts.push_back(pos >= mpc_pkg::MIN_LAST_INDEX
					&& value == mpc_pkg::LINE_FEED && verb_seen && marker_seen);
				payloads++;
				start_payload();
			end else begin
				// the marker only counts when it ends on a non-final byte
				if (pos >= mpc_pkg::MARKER_MIN_INDEX && window == mpc_pkg::MARKER_WORD)
					marker_seen = 1'b1;
				if (pos != mpc_pkg::IDX_MAX)
					byte_count = pos + 1'b1;
			end
		endfunction

		function void check_verdict(logic actual);
			bit want;
			if (expected_verdicts.size() == 0) begin
				$display("%0t ns: is_mgcp expected none, actual %0b", $time, actual);
				errors++;
			end else begin
				want = expected_verdicts.pop_front();
				if (actual !== want) begin
					$display("%0t ns: is_mgcp expected %0b, actual %0b", $time, want, actual);
					errors++;
				end
				if (actual === 1'b1)
					mgcp_hits++;
			end
		endfunction
	endclass

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic [7:0] payload_byte = 8'h00;
	logic       is_last      = 1'b0;
	logic       out_ready    = 1'b0;
	wire        in_ready;
	wire        out_valid;
	wire        is_mgcp;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	mgcp_verdict_scoreboard sb;

	mgcp_payload_classifier_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload_byte (payload_byte),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_mgcp      (is_mgcp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watch both channels and feed the scoreboard
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_byte(payload_byte, is_last);
		if (out_valid && out_ready)
			sb.check_verdict(is_mgcp);
	end

	// Drive out_ready: random idling, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void push_text(ref logic [7:0] text[$], input string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endfunction

	// Build one payload: mostly well-formed commands, some damaged, some noise
	function automatic void make_payload(ref logic [7:0] text[$], input shape_t shape);
		mpc_pkg::word5_t verb;
		flaw_t           flaw;
		int              pick;
		text.delete();
		if (shape == SHAPE_NOISE) begin
			repeat ($urandom_range(1, 24))
				text.push_back(8'($urandom));
			return;
		end
		flaw = flaw_t'($urandom_range(0, 5));
		verb = mpc_pkg::VERB_TABLE[$urandom_range(0, mpc_pkg::VERB_COUNT - 1)];
		// a missing verb lets the marker land at the low offsets
		if (shape == SHAPE_BROKEN && flaw == FLAW_NO_VERB) begin
			repeat ($urandom_range(0, 4))
				text.push_back(8'($urandom_range(32, 126)));
		end else begin
			for (int k = 4; k >= 0; k--)
				text.push_back(verb[8*k +: 8]);
		end
		repeat ($urandom_range(0, 12))
			text.push_back(8'($urandom_range(32, 126)));
		if (shape == SHAPE_BROKEN && flaw == FLAW_BAD_MARKER) begin
			push_text(text, "MGCP");
			text.push_back(8'($urandom));
		end else begin
			push_text(text, "MGCP ");
		end
		repeat ($urandom_range(0, 12))
			text.push_back(8'($urandom_range(32, 126)));
		if ($urandom_range(1))
			text.push_back(8'h0d);
		text.push_back(mpc_pkg::LINE_FEED);
		if (shape == SHAPE_BROKEN) begin
			pick = $urandom_range(0, text.size() - 1);
			case (flaw)
				FLAW_BIT_FLIP: begin
					text[pick] = text[pick] ^ (8'h01 << $urandom_range(0, 7));
				end
				FLAW_BAD_END: begin
					text[text.size() - 1] = 8'($urandom);
				end
				FLAW_TRUNCATE: begin
					while (text.size() > pick + 1)
						void'(text.pop_back());
				end
				FLAW_TRAILER: begin
					repeat ($urandom_range(1, 3))
						text.push_back(8'($urandom));
				end
				default: begin
				end
			endcase
		end
	endfunction

	// Offer one byte, idling first at the current rate, and hold until accepted
	task automatic send_byte(input logic [7:0] value, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		payload_byte <= value;
		is_last      <= last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_payload(ref logic [7:0] text[$]);
		for (int i = 0; i < text.size(); i++)
			send_byte(text[i], i == text.size() - 1);
	endtask

	initial begin : main
		logic [7:0] text[$];
		int         phase_bytes;
		int         pick;
		int         waited;
		shape_t     shape;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: shortest MGCP command, one-byte payload, short zero-filled payload ending in a line feed
		push_text(text, "AUEP MGCP \n");
		send_payload(text);
		text.delete();
		text.push_back(8'hff);
		send_payload(text);
		text.delete();
		repeat (7) text.push_back(8'h00);
		text.push_back(mpc_pkg::LINE_FEED);
		send_payload(text);

		// Random: sender-light idling, receiver-light idling, then full rate with a long output stall
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 84;
				end
				1: begin
					send_idle_pct = 84;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_requests++;
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				pick  = $urandom_range(99);
				shape = pick < 70 ? SHAPE_GOOD : (pick < 90 ? SHAPE_BROKEN : SHAPE_NOISE);
				make_payload(text, shape);
				send_payload(text);
				phase_bytes += text.size();
			end
		end

		// Long command: the marker shows up far past the verb
		text.delete();
		push_text(text, "NTFY ");
		repeat (LONG_FILL) text.push_back(8'($urandom_range(32, 126)));
		push_text(text, "MGCP \r\n");
		send_payload(text);
		in_valid <= 1'b0;

		// Drain outstanding verdicts, then watch for strays
		waited = 0;
		while (sb.expected_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (sb.expected_verdicts.size() != 0) begin
			$display("%0t ns: %0d verdicts never arrived", $time, sb.expected_verdicts.size());
			sb.errors++;
		end

		$display("Run covered %0d payloads in %0d bytes, %0d judged MGCP, with %0d mismatches.",
			sb.payloads, sb.bytes_seen, sb.mgcp_hits, sb.errors);
		$display("Included were short, damaged and noise payloads, a long output stall and a %0d-byte payload.",
			LONG_FILL + 12);
		if (sb.errors == 0) begin
			$display("mgcp_payload_classifier_top: match");
		end else begin
			$display("mgcp_payload_classifier_top: mismatch");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#20_000_000;
		$display("%0t ns: run timed out", $time);
		$display("mgcp_payload_classifier_top: mismatch");
		$finish;
	end

endmodule
